### hdl/crtd_pkg.sv
// Shared types, constants and helpers for the CMOS RTC time decoder.
// Used by crtd_decode, crtd_check and cmos_rtc_time_decode_core; no dependencies.
`default_nettype none

package crtd_pkg;

  // Configuration register layout
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int YEAR_W     = 14;
  localparam int CENT_W     = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MAX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_CENTURY = 2'd2;

  localparam logic [YEAR_W-1:0] YEAR_MIN_RST    = 14'd2000;
  localparam logic [YEAR_W-1:0] YEAR_MAX_RST    = 14'd2099;
  localparam logic [CENT_W-1:0] DEF_CENTURY_RST = 7'd20;

  // Status B and hour byte bit positions
  localparam int SB_BINARY_BIT = 2;
  localparam int SB_24H_BIT    = 1;
  localparam int HOUR_PM_BIT   = 7;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_BCD    = 2'd1;
  localparam logic [1:0] ERR_HOUR12 = 2'd2;
  localparam logic [1:0] ERR_RANGE  = 2'd3;

  typedef struct packed {
    logic [7:0] raw_seconds;
    logic [7:0] raw_minutes;
    logic [7:0] raw_hours;
    logic [7:0] raw_day;
    logic [7:0] raw_month;
    logic [7:0] raw_year;
    logic [7:0] raw_century;
    logic [7:0] raw_status;
  } crtd_in_t;

  typedef struct packed {
    logic [1:0]        error_code;
    logic [YEAR_W-1:0] full_year;
    logic [3:0]        month_out;
    logic [4:0]        day_out;
    logic [4:0]        hour_out;
    logic [5:0]        minute_out;
    logic [5:0]        second_out;
  } crtd_out_t;

  // Decoded fields and fault flags handed from decode to check
  typedef struct packed {
    logic       bcd_err;
    logic       hour_err;
    logic       cen_err;
    logic [7:0] second;
    logic [7:0] minute;
    logic [6:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year2;
    logic [7:0] century;
  } crtd_dec_t;

  function automatic logic bcd_bad(input logic [7:0] raw);
    return (raw[3:0] > 4'd9) || (raw[7:4] > 4'd9);
  endfunction

  function automatic logic [7:0] byte_value(input logic [7:0] raw, input logic binary);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0, raw[7:4]};
    lo = {4'b0, raw[3:0]};
    if (binary) begin
      return raw;
    end
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### hdl/crtd_decode.sv
// Field decoder: BCD or binary bytes, 12-to-24 hour mapping, century select.
// Depends on crtd_pkg.
`default_nettype none

module crtd_decode (
  input  crtd_pkg::crtd_in_t           snap,
  input  logic [crtd_pkg::CENT_W-1:0]  default_century,
  output crtd_pkg::crtd_dec_t          dec
);
  import crtd_pkg::*;

  logic       binary;
  logic       mode12;
  logic       pm;
  logic [7:0] hour_byte;
  logic [7:0] hour_val;
  logic [6:0] hour_raw;
  logic [6:0] hour_map;

  assign binary    = snap.raw_status[SB_BINARY_BIT];
  assign mode12    = ~snap.raw_status[SB_24H_BIT];
  assign pm        = snap.raw_hours[HOUR_PM_BIT];
  // Drop the PM flag before decoding in either mode
  assign hour_byte = {1'b0, snap.raw_hours[6:0]};
  assign hour_val  = byte_value(hour_byte, binary);
  assign hour_raw  = hour_val[6:0];

  always_comb begin
    hour_map = hour_raw;
    if (mode12) begin
      if (pm && (hour_raw < 7'd12)) begin
        hour_map = hour_raw + 7'd12;
      end else if (!pm && (hour_raw == 7'd12)) begin
        hour_map = 7'd0;
      end
    end
  end

  always_comb begin
    dec.bcd_err  = !binary && (bcd_bad(snap.raw_seconds) || bcd_bad(snap.raw_minutes) ||
                               bcd_bad(hour_byte) || bcd_bad(snap.raw_day) ||
                               bcd_bad(snap.raw_month) || bcd_bad(snap.raw_year));
    dec.hour_err = mode12 && ((hour_raw == 7'd0) || (hour_raw > 7'd12));
    dec.cen_err  = !binary && (snap.raw_century != 8'd0) && bcd_bad(snap.raw_century);
    dec.second   = byte_value(snap.raw_seconds, binary);
    dec.minute   = byte_value(snap.raw_minutes, binary);
    dec.hour     = hour_map;
    dec.day      = byte_value(snap.raw_day, binary);
    dec.month    = byte_value(snap.raw_month, binary);
    dec.year2    = byte_value(snap.raw_year, binary);
    dec.century  = (snap.raw_century == 8'd0) ? {1'b0, default_century}
                                              : byte_value(snap.raw_century, binary);
  end

endmodule

`default_nettype wire

### hdl/crtd_check.sv
// Range checker: full year, window, leap year, month length, error priority.
// Depends on crtd_pkg.
`default_nettype none

module crtd_check (
  input  crtd_pkg::crtd_dec_t          dec,
  input  logic [crtd_pkg::YEAR_W-1:0]  year_min,
  input  logic [crtd_pkg::YEAR_W-1:0]  year_max,
  output crtd_pkg::crtd_out_t          res
);
  import crtd_pkg::*;

  logic [14:0] full;
  logic [1:0]  cent_q;
  logic [7:0]  year_rem;
  logic [1:0]  cent_adj;
  logic        leap;
  logic [4:0]  mlen;
  logic        range_bad;
  logic [1:0]  err;

  // century*100 + year, never wraps in 15 bits
  assign full = ({7'b0, dec.century} * 15'd100) + {7'b0, dec.year2};

  // Fold the two-digit year into [0,100) so full = (century+q)*100 + rem
  always_comb begin
    if (dec.year2 >= 8'd200) begin
      cent_q = 2'd2;
    end else if (dec.year2 >= 8'd100) begin
      cent_q = 2'd1;
    end else begin
      cent_q = 2'd0;
    end
  end

  assign year_rem = dec.year2 - ({6'b0, cent_q} * 8'd100);
  assign cent_adj = dec.century[1:0] + cent_q;
  assign leap     = (dec.year2[1:0] == 2'd0) && ((year_rem != 8'd0) || (cent_adj == 2'd0));
  assign mlen     = month_len(dec.month[3:0], leap);

  assign range_bad = (full < {1'b0, year_min}) || (full > {1'b0, year_max}) ||
                     (dec.month == 8'd0) || (dec.month > 8'd12) ||
                     (dec.hour > 7'd23) || (dec.minute > 8'd59) || (dec.second > 8'd59) ||
                     (dec.day == 8'd0) || (dec.day > {3'b0, mlen});

  always_comb begin
    if (dec.bcd_err) begin
      err = ERR_BCD;
    end else if (dec.hour_err) begin
      err = ERR_HOUR12;
    end else if (dec.cen_err) begin
      err = ERR_BCD;
    end else if (range_bad) begin
      err = ERR_RANGE;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    res = '0;
    res.error_code = err;
    if (err == ERR_NONE) begin
      res.full_year  = full[YEAR_W-1:0];
      res.month_out  = dec.month[3:0];
      res.day_out    = dec.day[4:0];
      res.hour_out   = dec.hour[4:0];
      res.minute_out = dec.minute[5:0];
      res.second_out = dec.second[5:0];
    end
  end

endmodule

`default_nettype wire

### hdl/cmos_rtc_time_decode_core.sv
// Top level of the CMOS RTC time decoder: input register, decode/check logic, result register.
// Depends on crtd_pkg, crtd_decode and crtd_check.
`default_nettype none

// Decodes one raw CMOS real-time-clock snapshot (seconds through century plus
// status B) into a checked 24-hour calendar time. Fields are packed BCD, or
// binary when status B bit 2 is set; bad BCD digits give error 1, a 12-hour
// hour outside 1..12 gives error 2, and a year outside [year_min, year_max],
// a bad month, an out-of-range time or a day beyond the month length (with
// Gregorian leap years) gives error 3. A raw century of zero takes the
// configured default century. All time fields read zero when error_code is
// not zero. Throughput is one snapshot per clock while out_stall is low: each
// transfer is captured in the input register, decoded and checked by
// combinational logic, and then moves into the result register, which drives
// out_valid. The input side keeps taking transfers while a result waits,
// until both the input register and the result register are full and
// out_stall is high. Write the configuration registers (0 year_min,
// 1 year_max, 2 default_century) only while no transfer is in flight.
module cmos_rtc_time_decode_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  crtd_pkg::crtd_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output crtd_pkg::crtd_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [crtd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crtd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import crtd_pkg::*;

  logic [YEAR_W-1:0] year_min_r;
  logic [YEAR_W-1:0] year_max_r;
  logic [CENT_W-1:0] def_century_r;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  crtd_in_t   s1_data_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  crtd_out_t  out_data_r;

  crtd_dec_t  dec;
  crtd_out_t  res;

  logic       out_free;
  logic       s1_adv;
  logic       in_xfer;

  // Configuration registers: mask to width, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_min_r    <= YEAR_MIN_RST;
      year_max_r    <= YEAR_MAX_RST;
      def_century_r <= DEF_CENTURY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_YEAR_MIN:    year_min_r    <= cfg_wdata[YEAR_W-1:0];
        CFG_YEAR_MAX:    year_max_r    <= cfg_wdata[YEAR_W-1:0];
        CFG_DEF_CENTURY: def_century_r <= cfg_wdata[CENT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: the result register frees up when empty or being taken;
  // the input register advances into it whenever it is free.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  crtd_decode u_decode (
    .snap            (s1_data_r),
    .default_century (def_century_r),
    .dec             (dec)
  );

  crtd_check u_check (
    .dec      (dec),
    .year_min (year_min_r),
    .year_max (year_max_r),
    .res      (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_err_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.error_code != ERR_NONE)) |->
      ((out_data_r.full_year == '0) && (out_data_r.month_out == '0) &&
       (out_data_r.day_out == '0) && (out_data_r.hour_out == '0) &&
       (out_data_r.minute_out == '0) && (out_data_r.second_out == '0)))
    else $error("error result carries nonzero time fields");

  a_ok_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.error_code == ERR_NONE)) |->
      ((out_data_r.month_out != 4'd0) && (out_data_r.month_out <= 4'd12) &&
       (out_data_r.day_out != 5'd0) && (out_data_r.hour_out <= 5'd23) &&
       (out_data_r.minute_out <= 6'd59) && (out_data_r.second_out <= 6'd59)))
    else $error("accepted result has a field out of range");

  a_queued_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("queued snapshot dropped while result stalled");

  a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced snapshot did not reach the result register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
